// File: hw/rtl/pg_pkg.sv
// ----------------------------------------------------------------------------
// pg_pkg
// Shared types and constants for the 3x3 Prewitt gradient block.
// ----------------------------------------------------------------------------
package pg_pkg;

  localparam int DEF_MAX_COLUMNS   = 2048;
  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int MAX_ROWS   = 2048;
  localparam int CFG_W      = 12;
  localparam int ROW_W      = 11;
  localparam int COORD_W    = 11;
  localparam int GRAD_W     = 24;
  localparam int GRAD_LIMIT = 8388607;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(2048);
  localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(2048);
  localparam logic [CFG_W-1:0] MIN_EXTENT    = CFG_W'(3);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                   empty;
    logic [QUEUE_LVL_W-1:0] level;
  } queue_status_t;

endpackage

// File: hw/rtl/pg_stream_if.sv
// ----------------------------------------------------------------------------
// pg_stream_if
// Valid/ready channels for pixels in and gradient results out.
// ----------------------------------------------------------------------------
interface pg_pixel_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          no_data;
  logic                          masked_out;

  modport source (output valid, output sample, output no_data, output masked_out,
                  input ready);
  modport sink   (input valid, input sample, input no_data, input masked_out,
                  output ready);
endinterface

interface pg_grad_if import pg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       centre_row;
  logic [COORD_W-1:0]       centre_col;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     window_valid;
  logic                     last_of_image;

  modport source (output valid, output centre_row, output centre_col, output grad_x,
                  output grad_y, output window_valid, output last_of_image,
                  input ready);
  modport sink   (input valid, input centre_row, input centre_col, input grad_x,
                  input grad_y, input window_valid, input last_of_image,
                  output ready);
endinterface

// File: hw/rtl/pg_front.sv
// ----------------------------------------------------------------------------
// pg_front
// Pixel intake: raster counters, line memory, 3x3 window and gradient sums.
// ----------------------------------------------------------------------------
module pg_front import pg_pkg::*; #(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int PAY_W         = 2 * COORD_W + 2 + 2 * (SAMPLE_BITS + 3)
) (
  input  logic                  clk,
  input  logic                  rst,
  pg_pixel_if.sink              pixel_in,
  input  logic                  write_enable,
  input  logic [0:0]            reg_index,
  input  logic [CFG_W-1:0]      write_data,
  input  queue_status_t         queue_status,
  output logic                  push,
  output logic [PAY_W-1:0]      push_data
);

  localparam int PIX_W = SAMPLE_BITS + 1;
  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int DW    = SAMPLE_BITS + 3;
  localparam int CNT_W = $clog2(MAX_COLUMNS);
  localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

  logic [CFG_W-1:0] image_columns;
  logic [CFG_W-1:0] image_rows;
  logic [CNT_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // upper entry in the low half, middle entry in the high half
  logic [2*PIX_W-1:0] line_mem [MAX_COLUMNS];
  logic [2*PIX_W-1:0] rd_word;

  logic               a_valid;
  logic               a_emit;
  logic               a_last;
  logic [CNT_W-1:0]   a_addr;
  logic [PIX_W-1:0]   a_pix;
  logic [COORD_W-1:0] a_row;
  logic [COORD_W-1:0] a_col;

  logic               b_valid;
  logic               b_emit;
  logic               b_last;
  logic [COORD_W-1:0] b_row;
  logic [COORD_W-1:0] b_col;
  logic [PIX_W-1:0]   win [9];

  logic [CMP_W-1:0]   cols_eff;
  logic [CFG_W-1:0]   rows_eff;
  logic               last_col;
  logic               last_row;
  logic               emit;
  logic               accept;
  logic [PIX_W-1:0]   cur_pix;
  logic [QUEUE_LVL_W:0] committed;

  logic signed [SUM_W-1:0] sum_right, sum_left, sum_top, sum_bottom;
  logic signed [DW-1:0]    diff_x, diff_y;
  logic                    no_data_seen;

  function automatic logic signed [SUM_W-1:0] pix_value(input logic [PIX_W-1:0] p);
    pix_value = SUM_W'($signed(p[SAMPLE_BITS-1:0]));
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_columns <= COLUMNS_RESET;
      image_rows    <= ROWS_RESET;
    end else if (write_enable) begin
      unique case (reg_index_t'(reg_index))
        REG_COLUMNS: image_columns <= write_data;
        REG_ROWS:    image_rows    <= write_data;
      endcase
    end
  end

  always_comb begin
    if (image_columns < MIN_EXTENT) begin
      cols_eff = CMP_W'(MIN_EXTENT);
    end else if (CMP_W'(image_columns) > CMP_W'(MAX_COLUMNS)) begin
      cols_eff = CMP_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CMP_W'(image_columns);
    end
    if (image_rows < MIN_EXTENT) begin
      rows_eff = MIN_EXTENT;
    end else if (image_rows > CFG_W'(MAX_ROWS)) begin
      rows_eff = CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = image_rows;
    end
  end

  assign last_col = (CMP_W'(col_count) + CMP_W'(1)) >= cols_eff;
  assign last_row = (CFG_W'(row_count) + CFG_W'(1)) >= rows_eff;
  assign emit     = (row_count >= ROW_W'(2)) && (col_count >= CNT_W'(2));
  assign cur_pix  = pixel_in.masked_out ? '0 :
                    {pixel_in.no_data, pixel_in.sample[SAMPLE_BITS-1:0]};

  // only requests that will produce a result need queue space
  assign committed = (QUEUE_LVL_W+1)'(queue_status.level)
                   + (QUEUE_LVL_W+1)'(a_valid && a_emit)
                   + (QUEUE_LVL_W+1)'(b_valid && b_emit);
  assign pixel_in.ready = committed < (QUEUE_LVL_W+1)'(QUEUE_DEPTH);
  assign accept = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  // line memory: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col_count];
    end
    if (a_valid) begin
      line_mem[a_addr] <= {a_pix, rd_word[2*PIX_W-1:PIX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_emit <= emit;
      a_last <= last_col && last_row;
      a_addr <= col_count;
      a_pix  <= cur_pix;
      a_row  <= row_count - ROW_W'(1);
      a_col  <= COORD_W'(col_count - CNT_W'(1));
    end
    if (a_valid) begin
      b_emit <= a_emit;
      b_last <= a_last;
      b_row  <= a_row;
      b_col  <= a_col;
      for (int i = 0; i < 3; i++) begin
        win[i*3]   <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= rd_word[PIX_W-1:0];
      win[5] <= rd_word[2*PIX_W-1:PIX_W];
      win[8] <= a_pix;
    end
  end

  always_comb begin
    no_data_seen = 1'b0;
    for (int i = 0; i < 9; i++) begin
      no_data_seen = no_data_seen | win[i][SAMPLE_BITS];
    end
    sum_right  = pix_value(win[2]) + pix_value(win[5]) + pix_value(win[8]);
    sum_left   = pix_value(win[0]) + pix_value(win[3]) + pix_value(win[6]);
    sum_top    = pix_value(win[0]) + pix_value(win[1]) + pix_value(win[2]);
    sum_bottom = pix_value(win[6]) + pix_value(win[7]) + pix_value(win[8]);
    if (no_data_seen) begin
      diff_x = '0;
      diff_y = '0;
    end else begin
      diff_x = DW'(sum_right) - DW'(sum_left);
      diff_y = DW'(sum_top) - DW'(sum_bottom);
    end
  end

  assign push      = b_valid && b_emit;
  assign push_data = {b_row, b_col, b_last, ~no_data_seen, diff_x, diff_y};

endmodule

// File: hw/rtl/pg_queue.sv
// ----------------------------------------------------------------------------
// pg_queue
// Short register queue between the window front and the divide back end.
// ----------------------------------------------------------------------------
module pg_queue import pg_pkg::*; #(
  parameter int WIDTH = 2 * COORD_W + 2 + 2 * (DEF_SAMPLE_BITS + 3)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output queue_status_t    status
);

  logic [WIDTH-1:0]       slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_LVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      level <= level + QUEUE_LVL_W'(push) - QUEUE_LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = slots[rd_ptr];
  assign status.level = level;
  assign status.empty = (level == '0);

endmodule

// File: hw/rtl/pg_back.sv
// ----------------------------------------------------------------------------
// pg_back
// Divide by six with floor, saturation and the registered result channel.
// ----------------------------------------------------------------------------
module pg_back import pg_pkg::*; #(
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int PAY_W         = 2 * COORD_W + 2 + 2 * (SAMPLE_BITS + 3)
) (
  input  logic             clk,
  input  logic             rst,
  input  queue_status_t    queue_status,
  input  logic [PAY_W-1:0] pop_data,
  output logic             pop,
  pg_grad_if.source        grad_out
);

  localparam int DW   = SAMPLE_BITS + 3;
  localparam int K    = DW - 1 + FRACTION_BITS;   // |diff * 2^F| < 2^K
  localparam int XW   = K + 3;
  localparam int YW   = K + 2;
  localparam int SH   = YW + 1;
  localparam int QTW  = 2 * YW - SH;
  localparam int QW   = (K + 2 > GRAD_W + 1) ? K + 2 : GRAD_W + 1;
  localparam int META = 2 * COORD_W + 2;

  // biased so the numerator is never negative
  localparam logic [XW-1:0] OFFSET = XW'(64'd6 << K);
  localparam logic [YW-1:0] RECIP  = YW'(((64'd1 << SH) + 64'd2) / 64'd3);
  localparam logic signed [QW-1:0] BIAS = QW'(64'd1 << K);
  localparam logic signed [QW-1:0] HI   = QW'(GRAD_LIMIT);
  localparam logic signed [QW-1:0] LO   = -QW'(GRAD_LIMIT);

  logic                  advance;
  logic                  s1_valid, s2_valid, out_valid;
  logic [META-1:0]       s1_meta, s2_meta, out_meta;
  logic [YW-1:0]         s1_half [2];
  logic [QTW-1:0]        s2_quot [2];
  logic signed [GRAD_W-1:0] out_grad [2];
  logic signed [DW-1:0]  in_diff [2];
  logic signed [XW-1:0]  scaled [2];
  logic [XW-1:0]         biased [2];
  logic [2*YW-1:0]       product [2];
  logic signed [QW-1:0]  quot [2];
  logic signed [GRAD_W-1:0] sat [2];

  assign advance = !out_valid || grad_out.ready;
  assign pop     = advance && !queue_status.empty;

  assign in_diff[0] = pop_data[2*DW-1:DW];
  assign in_diff[1] = pop_data[DW-1:0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      scaled[l]  = XW'(in_diff[l]) <<< FRACTION_BITS;
      biased[l]  = $unsigned(scaled[l]) + OFFSET;
      product[l] = (2*YW)'(s1_half[l]) * (2*YW)'(RECIP);
      quot[l]    = $signed(QW'(s2_quot[l])) - BIAS;
      if (quot[l] > HI) begin
        sat[l] = GRAD_W'(HI);
      end else if (quot[l] < LO) begin
        sat[l] = GRAD_W'(LO);
      end else begin
        sat[l] = GRAD_W'(quot[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta  <= pop_data[PAY_W-1:2*DW];
      s2_meta  <= s1_meta;
      out_meta <= s2_meta;
      for (int l = 0; l < 2; l++) begin
        // halving first keeps the reciprocal product exact
        s1_half[l]  <= biased[l][XW-1:1];
        s2_quot[l]  <= product[l][2*YW-1:SH];
        out_grad[l] <= sat[l];
      end
    end
  end

  assign grad_out.valid         = out_valid;
  assign grad_out.centre_row    = out_meta[META-1:META-COORD_W];
  assign grad_out.centre_col    = out_meta[META-COORD_W-1:2];
  assign grad_out.last_of_image = out_meta[1];
  assign grad_out.window_valid  = out_meta[0];
  assign grad_out.grad_x        = out_grad[0];
  assign grad_out.grad_y        = out_grad[1];

endmodule

// File: hw/rtl/prewitt_gradient_3x3.sv
// ----------------------------------------------------------------------------
// prewitt_gradient_3x3
// Streaming 3x3 Prewitt X and Y gradients over a raster in row order.
// ----------------------------------------------------------------------------
// Takes one pixel and gives one result per clock per interior centre unless
// the queue fills or the output stalls. Each pixel makes one read and one
// write-back of one line memory that holds the upper and middle rows side by
// side, which sets the rate. A result passes registers a and b, a four-entry
// queue and divide stages s1, s2 and out after its lower-right neighbour is
// taken; the queue lets the input keep going for a few results during an
// output stall. The line memory needs no clearing after reset.
module prewitt_gradient_3x3 import pg_pkg::*; #(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst,
  pg_pixel_if.sink         pixel_in,
  pg_grad_if.source        grad_out,
  input  logic             write_enable,
  input  logic [0:0]       reg_index,
  input  logic [CFG_W-1:0] write_data
);

  localparam int PAY_W = 2 * COORD_W + 2 + 2 * (SAMPLE_BITS + 3);

  logic             push;
  logic [PAY_W-1:0] push_data;
  logic             pop;
  logic [PAY_W-1:0] pop_data;
  queue_status_t    queue_status;

  pg_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PAY_W       (PAY_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_in     (pixel_in),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .queue_status (queue_status),
    .push         (push),
    .push_data    (push_data)
  );

  pg_queue #(
    .WIDTH (PAY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (queue_status)
  );

  pg_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .PAY_W         (PAY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_status (queue_status),
    .pop_data     (pop_data),
    .pop          (pop),
    .grad_out     (grad_out)
  );

endmodule

// File: hw/rtl/pg_checker.sv
// ----------------------------------------------------------------------------
// pg_checker
// Port-level checks on the gradient result channel.
// ----------------------------------------------------------------------------
module pg_checker import pg_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [COORD_W-1:0]       centre_row,
  input logic [COORD_W-1:0]       centre_col,
  input logic signed [GRAD_W-1:0] grad_x,
  input logic signed [GRAD_W-1:0] grad_y,
  input logic                     window_valid
);

  localparam logic [GRAD_W-1:0] MOST_NEG = {1'b1, {(GRAD_W-1){1'b0}}};

  // a stalled request keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(grad_y)
      && $stable(centre_row) && $stable(centre_col))
    else $error("result changed while stalled");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_valid |-> grad_x == '0 && grad_y == '0)
    else $error("gradients not zero on a no-data window");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_row != '0 && centre_col != '0)
    else $error("border centre emitted");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> grad_x != MOST_NEG && grad_y != MOST_NEG)
    else $error("gradient outside saturation range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind prewitt_gradient_3x3 pg_checker u_pg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (grad_out.valid),
  .out_ready    (grad_out.ready),
  .centre_row   (grad_out.centre_row),
  .centre_col   (grad_out.centre_col),
  .grad_x       (grad_out.grad_x),
  .grad_y       (grad_out.grad_y),
  .window_valid (grad_out.window_valid)
);
